### rtl/core/bdeq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bdeq_pkg;

  // Default number of stored words.
  localparam int DEPTH_DEFAULT = 16;

  // Fixed field widths of the request and response words.
  localparam int DATA_W       = 32;
  localparam int ITEM_COUNT_W = 5;

  // Request codes.
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_BACK   = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL = 2'd2;

  // Request word.
  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] push_value;
  } req_t;

  // Response word.
  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic [ITEM_COUNT_W-1:0]  item_count;
    logic                     queue_empty;
    logic [1:0]               status;
  } rsp_t;

  // What one cell loads in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT,
    CELL_TAKE_NEW
  } cell_op_t;

  // Command to one row of cells: insert at the head (shift toward the tail),
  // remove the head (shift toward the head), or write at the tail position.
  typedef struct packed {
    logic ins_head;
    logic rem_head;
    logic wr_tail;
  } chain_cmd_t;

endpackage

### rtl/core/bdeq_cell.sv
// One storage cell of a row: holds a word and takes a neighbor's word or a new one.
// Depends on bdeq_pkg.
`timescale 1ns / 1ps

module bdeq_cell (
  input  logic                               clk,
  input  bdeq_pkg::cell_op_t                 op,
  input  logic signed [bdeq_pkg::DATA_W-1:0] left_value,
  input  logic signed [bdeq_pkg::DATA_W-1:0] right_value,
  input  logic signed [bdeq_pkg::DATA_W-1:0] new_value,
  output logic signed [bdeq_pkg::DATA_W-1:0] value
);
  import bdeq_pkg::*;

  logic signed [DATA_W-1:0] value_next;

  // Select the word loaded at the next edge.
  always_comb begin
    case (op)
      CELL_TAKE_LEFT:  value_next = left_value;
      CELL_TAKE_RIGHT: value_next = right_value;
      CELL_TAKE_NEW:   value_next = new_value;
      default:         value_next = value;
    endcase
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### rtl/core/bdeq_chain.sv
// A row of cells holding the queue in order from its head position.
// Depends on bdeq_pkg and bdeq_cell.
`timescale 1ns / 1ps

module bdeq_chain #(
  parameter int DEPTH = bdeq_pkg::DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  bdeq_pkg::chain_cmd_t               cmd,
  input  logic [CW-1:0]                      tail_idx,
  input  logic signed [bdeq_pkg::DATA_W-1:0] push_value,
  output logic signed [bdeq_pkg::DATA_W-1:0] head,
  output logic signed [bdeq_pkg::DATA_W-1:0] second
);
  import bdeq_pkg::*;

  logic signed [DATA_W-1:0] cell_value [DEPTH];

  assign head   = cell_value[0];
  assign second = cell_value[1];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_value;
    logic signed [DATA_W-1:0] right_value;
    cell_op_t                 op;

    // The head cell takes the pushed word on a shift toward the tail.
    if (i == 0) begin : g_first
      assign left_value = push_value;
    end else begin : g_inner_left
      assign left_value = cell_value[i-1];
    end

    // The last cell has no neighbor toward the tail.
    if (i == DEPTH - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_inner_right
      assign right_value = cell_value[i+1];
    end

    // Each cell decodes the row command on its own.
    always_comb begin
      if (cmd.ins_head) begin
        op = CELL_TAKE_LEFT;
      end else if (cmd.rem_head) begin
        op = CELL_TAKE_RIGHT;
      end else if (cmd.wr_tail && tail_idx == CW'(i)) begin
        op = CELL_TAKE_NEW;
      end else begin
        op = CELL_HOLD;
      end
    end

    bdeq_cell u_cell (
      .clk         (clk),
      .op          (op),
      .left_value  (left_value),
      .right_value (right_value),
      .new_value   (push_value),
      .value       (cell_value[i])
    );
  end

endmodule

### rtl/core/bounded_double_ended_queue_core.sv
// The response word is registered and shows in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is not stalled; the cells that a request moves update at once.
// A request is taken while the held response is being taken in the same cycle.
// Reset clears the count and the output valid; cell contents stay undefined until pushed.
// Depends on bdeq_pkg and bdeq_chain.
`timescale 1ns / 1ps

module bounded_double_ended_queue_core #(
  parameter int DEPTH = bdeq_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bdeq_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output bdeq_pkg::rsp_t out_data
);
  import bdeq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                accept;
  logic                full;
  logic                empty;
  logic                out_valid_next;
  chain_cmd_t          fwd_cmd;
  chain_cmd_t          rev_cmd;
  logic signed [DATA_W-1:0] fwd_head;
  logic signed [DATA_W-1:0] fwd_second;
  logic signed [DATA_W-1:0] rev_head;
  logic signed [DATA_W-1:0] rev_second;
  rsp_t                rsp;

  // A new word enters whenever the output register is free or being emptied.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);

  // The forward row keeps the front in its head cell, the reverse row the rear.
  bdeq_chain #(.DEPTH(DEPTH), .CW(CW)) u_fwd (
    .clk        (clk),
    .cmd        (fwd_cmd),
    .tail_idx   (count),
    .push_value (in_data.push_value),
    .head       (fwd_head),
    .second     (fwd_second)
  );

  bdeq_chain #(.DEPTH(DEPTH), .CW(CW)) u_rev (
    .clk        (clk),
    .cmd        (rev_cmd),
    .tail_idx   (count),
    .push_value (in_data.push_value),
    .head       (rev_head),
    .second     (rev_second)
  );

  // Decode the request into row commands, the new count and the response.
  always_comb begin
    fwd_cmd          = '0;
    rev_cmd          = '0;
    count_next       = count;
    rsp.popped_value = '0;
    rsp.front_value  = empty ? '0 : fwd_head;
    rsp.rear_value   = empty ? '0 : rev_head;
    rsp.status       = ST_OK;
    case (in_data.req_type)
      REQ_PUSH_FRONT: begin
        if (full) begin
          rsp.status = ST_PUSH_FULL;
        end else begin
          fwd_cmd.ins_head = accept;
          rev_cmd.wr_tail  = accept;
          count_next       = count + CW'(1);
          rsp.front_value  = in_data.push_value;
          rsp.rear_value   = empty ? in_data.push_value : rev_head;
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          rsp.status = ST_PUSH_FULL;
        end else begin
          rev_cmd.ins_head = accept;
          fwd_cmd.wr_tail  = accept;
          count_next       = count + CW'(1);
          rsp.rear_value   = in_data.push_value;
          rsp.front_value  = empty ? in_data.push_value : fwd_head;
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          rsp.status = ST_POP_EMPTY;
        end else begin
          fwd_cmd.rem_head = accept;
          count_next       = count - CW'(1);
          rsp.popped_value = fwd_head;
          rsp.front_value  = (count == CW'(1)) ? '0 : fwd_second;
          rsp.rear_value   = (count == CW'(1)) ? '0 : rev_head;
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          rsp.status = ST_POP_EMPTY;
        end else begin
          rev_cmd.rem_head = accept;
          count_next       = count - CW'(1);
          rsp.popped_value = rev_head;
          rsp.front_value  = (count == CW'(1)) ? '0 : fwd_head;
          rsp.rear_value   = (count == CW'(1)) ? '0 : rev_second;
        end
      end
      default: begin
        rsp.status = ST_OK;
      end
    endcase
    rsp.item_count  = ITEM_COUNT_W'(count_next);
    rsp.queue_empty = (count_next == '0);
  end

  // Output valid holds while stalled and drops once the word is taken, unless a new request is accepted.
  assign out_valid_next = accept || (out_valid && out_stall);

  // Count and output valid are control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // Response payload loads only with an accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= rsp;
    end
  end

endmodule

### rtl/core/bdeq_checker.sv
// Port-level checks for the bounded double-ended queue, bound to the top level.
// Depends on bdeq_pkg and bounded_double_ended_queue_core.
`timescale 1ns / 1ps

module bdeq_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input bdeq_pkg::req_t in_data,
  input logic           out_valid,
  input logic           out_stall,
  input bdeq_pkg::rsp_t out_data
);
  import bdeq_pkg::*;

  // A stalled response word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("response word changed while stalled");

  // An empty queue reports a zero count and zero end values.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.queue_empty |->
      out_data.item_count == '0 && out_data.front_value == '0 &&
      out_data.rear_value == '0)
    else $error("empty queue reports stale contents");

  // A failed request removes nothing and carries no popped word.
  a_no_pop_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.popped_value == '0)
    else $error("error response carries a popped word");

  // A pop from empty leaves the queue empty; a push into full leaves it non-empty.
  a_error_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_data.status != ST_POP_EMPTY || out_data.queue_empty) &&
      (out_data.status != ST_PUSH_FULL || !out_data.queue_empty))
    else $error("error status disagrees with empty flag");

endmodule

bind bounded_double_ended_queue_core bdeq_checker u_bdeq_checker (.*);

### tb/sv/bounded_double_ended_queue_core_test.sv
// Self-checking testbench for bounded_double_ended_queue_core: a directed table, then random
// push/pop traffic, with every response checked against a behavioral deque model or a typed row.
// Depends on bdeq_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module bounded_double_ended_queue_core_test;
  import bdeq_pkg::*;

  localparam int DEPTH          = DEPTH_DEFAULT;
  localparam int RANDOM_WORDS   = 1125;
  localparam int CALM_TAIL      = 150;
  localparam int HANDSHAKE_WAIT = 2000;

  // One row of the directed table; typed rows carry their expected response.
  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } table_row_t;

  typedef struct {
    bit   typed;
    rsp_t rsp;
  } typed_rsp_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  bounded_double_ended_queue_core #(.DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Deque model state: ring storage, index of the front slot and fill level.
  logic signed [DATA_W-1:0] ring [DEPTH];
  int head_idx   = 0;
  int fill_level = 0;

  rsp_t       expected_responses [$];
  typed_rsp_t typed_responses [$];
  table_row_t stim_table [$];

  int  error_count       = 0;
  int  words_sent        = 0;
  int  responses_checked = 0;
  int  pushes_stored     = 0;
  int  values_popped     = 0;
  int  empty_pops        = 0;
  int  full_pushes       = 0;
  int  quiet_cycles      = 0;
  int  stall_left        = 0;
  bit  idle_on           = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one request to the deque model and returns the response it implies.
  task automatic predict_response(input req_t r, output rsp_t rsp);
    rsp = '0;
    rsp.status = ST_OK;
    case (r.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (fill_level == DEPTH) begin
          rsp.status = ST_PUSH_FULL;
          full_pushes++;
        end else begin
          if (r.req_type == REQ_PUSH_FRONT) begin
            head_idx = (head_idx + DEPTH - 1) % DEPTH;
            ring[head_idx] = r.push_value;
          end else begin
            ring[(head_idx + fill_level) % DEPTH] = r.push_value;
          end
          fill_level++;
          pushes_stored++;
        end
      end
      default: begin
        if (fill_level == 0) begin
          rsp.status = ST_POP_EMPTY;
          empty_pops++;
        end else begin
          if (r.req_type == REQ_POP_FRONT) begin
            rsp.popped_value = ring[head_idx];
            head_idx = (head_idx + 1) % DEPTH;
          end else begin
            rsp.popped_value = ring[(head_idx + fill_level - 1) % DEPTH];
          end
          fill_level--;
          values_popped++;
        end
      end
    endcase
    if (fill_level != 0) begin
      rsp.front_value = ring[head_idx];
      rsp.rear_value  = ring[(head_idx + fill_level - 1) % DEPTH];
    end
    rsp.item_count  = fill_level[ITEM_COUNT_W-1:0];
    rsp.queue_empty = (fill_level == 0);
  endtask

  task automatic check_field(input string field_name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field_name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Predict on each accepted request word, then check each accepted response word.
  always @(posedge clk) begin
    rsp_t       want;
    typed_rsp_t row_rsp;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_response(in_data, want);
        row_rsp = typed_responses.pop_front();
        if (row_rsp.typed) want = row_rsp.rsp;
        expected_responses.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: unexpected response word: expected none, actual %h", $time, out_data);
          error_count++;
        end else begin
          want = expected_responses.pop_front();
          check_field("popped_value", want.popped_value, out_data.popped_value);
          check_field("front_value", want.front_value, out_data.front_value);
          check_field("rear_value", want.rear_value, out_data.rear_value);
          check_field("item_count", 32'(want.item_count), 32'(out_data.item_count));
          check_field("queue_empty", 32'(want.queue_empty), 32'(out_data.queue_empty));
          check_field("status", 32'(want.status), 32'(out_data.status));
        end
        responses_checked++;
      end
    end
  end

  // Receiver back-pressure: random stall bursts while idling is enabled.
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANDSHAKE_WAIT) begin
      $display("%0t: watchdog expired after %0d cycles without a handshake", $time,
               quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic table_row_t mk_row(input logic [1:0] kind, input logic [31:0] value,
                                        input bit typed, input logic [31:0] popped,
                                        input logic [31:0] front, input logic [31:0] rear,
                                        input int count, input bit empty,
                                        input logic [1:0] code);
    table_row_t row;
    row.req.req_type     = kind;
    row.req.push_value   = value;
    row.typed            = typed;
    row.rsp.popped_value = popped;
    row.rsp.front_value  = front;
    row.rsp.rear_value   = rear;
    row.rsp.item_count   = count[ITEM_COUNT_W-1:0];
    row.rsp.queue_empty  = empty;
    row.rsp.status       = code;
    return row;
  endfunction

  // Sends one request word, with an optional idle gap first, and waits for its acceptance.
  task automatic send_word(input req_t r, input bit typed, input rsp_t typed_rsp);
    typed_rsp_t row_rsp;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    row_rsp.typed = typed;
    row_rsp.rsp   = typed_rsp;
    typed_responses.push_back(row_rsp);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    words_sent++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    req_t r;
    int   segment_left;
    int   push_weight;
    in_valid  = 1'b0;
    in_data   = '0;
    rst       = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table: empty pops, extreme values, front index wrap, emptying, then a full queue.
    stim_table.push_back(mk_row(REQ_POP_FRONT, 32'h0, 1'b1, 0, 0, 0, 0, 1'b1, ST_POP_EMPTY));
    stim_table.push_back(mk_row(REQ_POP_BACK, 32'h1234_5678, 1'b1, 0, 0, 0, 0, 1'b1,
                                ST_POP_EMPTY));
    stim_table.push_back(mk_row(REQ_PUSH_BACK, 32'h7FFF_FFFF, 1'b1, 0, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 1, 1'b0, ST_OK));
    stim_table.push_back(mk_row(REQ_PUSH_FRONT, 32'h8000_0000, 1'b1, 0, 32'h8000_0000,
                                32'h7FFF_FFFF, 2, 1'b0, ST_OK));
    stim_table.push_back(mk_row(REQ_POP_BACK, 32'h0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'h8000_0000, 1, 1'b0, ST_OK));
    stim_table.push_back(mk_row(REQ_POP_FRONT, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 0, 0, 0,
                                1'b1, ST_OK));
    stim_table.push_back(mk_row(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, 0, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 1, 1'b0, ST_OK));
    for (int k = 0; k < DEPTH - 1; k++) begin
      stim_table.push_back(mk_row(REQ_PUSH_BACK, k, 1'b0, 0, 0, 0, 0, 1'b0, ST_OK));
    end
    stim_table.push_back(mk_row(REQ_PUSH_BACK, 32'h5555_5555, 1'b1, 0, 32'hFFFF_FFFF,
                                DEPTH - 2, DEPTH, 1'b0, ST_PUSH_FULL));
    stim_table.push_back(mk_row(REQ_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, 0, 32'hFFFF_FFFF,
                                DEPTH - 2, DEPTH, 1'b0, ST_PUSH_FULL));
    stim_table.push_back(mk_row(REQ_POP_FRONT, 32'h0, 1'b0, 0, 0, 0, 0, 1'b0, ST_OK));

    idle_on = 1'b1;
    foreach (stim_table[i]) send_word(stim_table[i].req, stim_table[i].typed,
                                      stim_table[i].rsp);

    // Random traffic in segments that lean toward filling, draining or neither.
    segment_left = 0;
    push_weight  = 2;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(20, 80);
        push_weight  = $urandom_range(1, 3);
        idle_on      = ($urandom_range(0, 3) != 0);
      end
      segment_left--;
      if (i >= RANDOM_WORDS - CALM_TAIL) idle_on = 1'b0;

      // Hold off once mid-run until every outstanding response has been seen.
      if (i == RANDOM_WORDS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (responses_checked < words_sent) @(posedge clk);
      end

      r.push_value = pick_value();
      if ($urandom_range(0, 3) < push_weight) begin
        r.req_type = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      end else begin
        r.req_type = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
      end
      send_word(r, 1'b0, '0);
    end

    // Drain: wait for every response, then check that no expected response is left over.
    in_valid <= 1'b0;
    @(posedge clk);
    while (responses_checked < words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_responses.size() != 0) begin
      $display("%0t: %0d expected responses never arrived", $time, expected_responses.size());
      error_count++;
    end

    $display("Sent %0d request words: %0d stored pushes, %0d pops, %0d pops on empty,",
             words_sent, pushes_stored, values_popped, empty_pops);
    $display("%0d pushes into a full queue; %0d response words compared.", full_pushes,
             responses_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
